// ----- src/dlcr_pkg.sv -----
// package for the dust low-complexity region finder
// holds sizes, payload structs, the sequencer state type and the shared status struct
// no dependencies
package dlcr_pkg;

	localparam int WINDOW        = 64;
	localparam int TRIPLET_LEN   = 3;
	localparam int MAX_INTERVALS = 64;

	localparam int RING     = WINDOW - TRIPLET_LEN + 1;
	localparam int WORD_W   = 2 * TRIPLET_LEN;
	localparam int NWORDS   = 1 << WORD_W;
	localparam int POS_W    = 31;
	localparam int THR_W    = 8;
	localparam int FILL_W   = $clog2(RING + 1);
	localparam int RIDX_W   = $clog2(RING);
	localparam int CNT_W    = FILL_W;
	localparam int TOT_W    = $clog2(RING * (RING - 1) / 2 + 1);
	localparam int ICNT_W   = $clog2(MAX_INTERVALS + 1);
	localparam int IIDX_W   = $clog2(MAX_INTERVALS);
	localparam int PROD_W   = TOT_W + THR_W + FILL_W;

	localparam logic [THR_W-1:0] THR_RESET = THR_W'(20);
	localparam int SCORE_MUL = 10;
	localparam int TRIM_MUL  = 2;
	localparam int BASE_MAX  = 3;

	typedef struct packed {
		logic [2:0] base_code;
		logic       sequence_end;
	} in_item_t;

	typedef struct packed {
		logic [POS_W-1:0] region_start;
		logic [POS_W-1:0] region_end;
		logic             last_of_run;
	} out_item_t;

	typedef struct packed {
		logic [2:0] base_code;
		logic       sequence_end;
		logic       amb;
	} q_item_t;

	typedef struct packed {
		logic [POS_W-1:0]  start;
		logic [POS_W-1:0]  stop;
		logic [TOT_W-1:0]  score;
		logic [FILL_W-1:0] len;
	} ivl_t;

	typedef struct packed {
		logic              busy;
		logic [ICNT_W-1:0] ivl_cnt;
		logic [FILL_W-1:0] fill;
		logic [FILL_W-1:0] vlen;
	} stat_t;

	typedef enum logic [4:0] {
		S_IDLE, S_AMB_RD, S_AMB_EM, S_CMP_RD, S_CMP_DO,
		S_OLD_RD, S_OLD_CNT, S_OLD_UPD, S_NEW_CNT, S_NEW_UPD,
		S_TRIM_RD, S_TRIM_CNT, S_TRIM_UPD, S_CHK,
		S_SRC_RD, S_SRC_CNT, S_SRC_UPD, S_SRC_TST,
		S_SCN_RD, S_SCN_DO, S_DEC, S_SHF_RD, S_SHF_WR, S_INS, S_FIN
	} state_t;

endpackage

// ----- src/dust_low_complexity_region_finder_top.sv -----
// top level of the dust low-complexity region finder
// depends on dlcr_pkg, dlcr_front and dlcr_back
//
// input channel in_valid/in_ready/in_data carries one base code per transfer;
// output channel out_valid/out_ready/out_data carries region start/end pairs,
// with last_of_run set on the final region caused by one input transfer.
// cfg_wr_en/cfg_wr_data write the score threshold (reset 20, zero disables).
// a two-entry queue decouples acceptance from the sequencer, so input
// transfers are taken while the sequencer works or a result waits.
// the sequencer handles one item at a time; an ambiguous base or a short run
// takes the shortest path, a new word a longer one, longer again once the ring
// is full, and the work grows with each stored interval for the window-leave
// sweep or the ambiguous flush, each trimmed word and, when the window score
// passes the threshold, each searched word, each word that passes and each
// interval scanned or shifted; the loops over the word ring and the interval
// ram set the time for one item.
// results of one item leave one behind the other, the last when the sequencer
// finishes the item.
// reset empties the queue and clears all counts and the interval list at once.
// a stalled receiver holds one result in the output register and one pending;
// the sequencer then waits and the queue fills before in_ready drops.
module dust_low_complexity_region_finder_top
	import dlcr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	input  logic             cfg_wr_en,
	input  logic [THR_W-1:0] cfg_wr_data
);

	logic [THR_W-1:0] thr_q;
	logic             q_valid;
	logic             q_ready;
	q_item_t          q_item;
	stat_t            stat;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q <= THR_RESET;
		end else if (cfg_wr_en) begin
			thr_q <= cfg_wr_data;
		end
	end

	dlcr_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.thr      (thr_q),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_data  (in_data),
		.q_valid  (q_valid),
		.q_ready  (q_ready),
		.q_item   (q_item)
	);

	dlcr_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.thr       (thr_q),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.stat      (stat)
	);

	a_fill_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.fill <= FILL_W'(RING))
		else $error("word ring fill beyond ring size");

	a_ivl_bound: assert property (@(posedge clk) disable iff (!arst_n)
		stat.ivl_cnt <= ICNT_W'(MAX_INTERVALS))
		else $error("interval count beyond list size");

	a_vlen_fill: assert property (@(posedge clk) disable iff (!arst_n)
		stat.vlen <= stat.fill)
		else $error("verbose region longer than window");

endmodule

// ----- src/dlcr_ram.sv -----
// generic single write port, single read port ram with registered read
// read data holds while the read enable is low
// no dependencies
module dlcr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

// ----- src/dlcr_front.sv -----
// front part: accepts input transfers, classifies them and queues them
// depends on dlcr_pkg
module dlcr_front
	import dlcr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [THR_W-1:0] thr,
	input  logic             in_valid,
	output logic             in_ready,
	input  in_item_t         in_data,
	output logic             q_valid,
	input  logic             q_ready,
	output q_item_t          q_item
);

	q_item_t    ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] n_q;
	logic       push;
	logic       pop;
	q_item_t    cls;

	always_comb begin
		cls.base_code    = in_data.base_code;
		cls.sequence_end = in_data.sequence_end;
		cls.amb          = in_data.sequence_end || (in_data.base_code > 3'(BASE_MAX))
			|| (thr == '0);
	end

	assign in_ready = (n_q != 2'd2);
	assign q_valid  = (n_q != 2'd0);
	assign q_item   = ent_q[rd_q];
	assign push     = in_valid && in_ready;
	assign pop      = q_ready && q_valid;

	always_ff @(posedge clk) begin
		if (push) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q <= 1'b0;
			rd_q <= 1'b0;
			n_q  <= 2'd0;
		end else begin
			if (push) begin
				wr_q <= ~wr_q;
			end
			if (pop) begin
				rd_q <= ~rd_q;
			end
			n_q <= n_q + 2'(push) - 2'(pop);
		end
	end

endmodule

// ----- src/dlcr_back.sv -----
// back part: sequencer over the word ring, triplet counts and interval list
// depends on dlcr_pkg and dlcr_ram
module dlcr_back
	import dlcr_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic [THR_W-1:0] thr,
	input  logic             q_valid,
	output logic             q_ready,
	input  q_item_t          q_item,
	output logic             out_valid,
	input  logic             out_ready,
	output out_item_t        out_data,
	output stat_t            stat
);

	localparam logic [POS_W-1:0] POS_MAX = {POS_W{1'b1}};

	state_t state_q, state_d;

	logic [POS_W-1:0]  pos_q, run_q, wstart_q, istart_q;
	logic [WORD_W-1:0] trip_q, bw_q;
	logic [RIDX_W-1:0] head_q;
	logic [FILL_W-1:0] fill_q, vlen_q, jp_q, tlen_q;
	logic [TOT_W-1:0]  wtot_q, vtot_q, tscore_q, best_s_q;
	logic [FILL_W-1:0] best_l_q;
	logic [ICNT_W-1:0] cnt_q, k_q, keep_q, kp_q, ins_q;
	logic [NWORDS-1:0] wval_q, vval_q, tval_q;
	logic              end_q, amb_q;

	logic              pend_v_q;
	logic [POS_W-1:0]  pend_s_q, pend_e_q;
	logic              out_v_q;
	out_item_t         out_q;

	// ram ports
	logic              rg_we, rg_re;
	logic [RIDX_W-1:0] rg_wa, rg_ra;
	logic [WORD_W-1:0] rg_wd, rg_rd;
	logic              wc_we, wc_re, vc_we, vc_re, tc_we, tc_re;
	logic [WORD_W-1:0] wc_wa, wc_ra, vc_wa, vc_ra, tc_wa, tc_ra;
	logic [CNT_W-1:0]  wc_wd, wc_rd, vc_wd, vc_rd, tc_wd, tc_rd;
	logic              iv_we, iv_re;
	logic [IIDX_W-1:0] iv_wa, iv_ra;
	ivl_t              iv_wd, iv_rd;

	logic              emit, flush, can_emit, can_flush;
	logic [POS_W-1:0]  emit_s, emit_e;

	logic [POS_W-1:0]  run_inc, span, wstart_new;
	logic [WORD_W-1:0] trip_new;
	logic              go_src;
	logic [CNT_W-1:0]  cw, cw_dec, cv, cv_dec, ct;
	logic [TOT_W-1:0]  wtot_take, vtot_take, ts_new;
	logic [PROD_W-1:0] lhs, rhs, lhs2, rhs2;

	function automatic logic [RIDX_W-1:0] ring_phys(input logic [RIDX_W-1:0] h,
		input logic [FILL_W-1:0] i);
		logic [FILL_W:0] s;
		s = (FILL_W+1)'(h) + (FILL_W+1)'(i);
		if (s >= (FILL_W+1)'(RING)) begin
			s = s - (FILL_W+1)'(RING);
		end
		return s[RIDX_W-1:0];
	endfunction

	function automatic logic [CNT_W-1:0] dec_sat(input logic [CNT_W-1:0] c);
		return (c != '0) ? c - CNT_W'(1) : '0;
	endfunction

	function automatic logic [TOT_W-1:0] sub_sat(input logic [TOT_W-1:0] t,
		input logic [CNT_W-1:0] c);
		return (t >= TOT_W'(c)) ? t - TOT_W'(c) : '0;
	endfunction

	dlcr_ram #(.WIDTH(WORD_W), .DEPTH(RING)) u_ring (
		.clk(clk), .we(rg_we), .waddr(rg_wa), .wdata(rg_wd),
		.re(rg_re), .raddr(rg_ra), .rdata(rg_rd)
	);
	dlcr_ram #(.WIDTH(CNT_W), .DEPTH(NWORDS)) u_wcnt (
		.clk(clk), .we(wc_we), .waddr(wc_wa), .wdata(wc_wd),
		.re(wc_re), .raddr(wc_ra), .rdata(wc_rd)
	);
	dlcr_ram #(.WIDTH(CNT_W), .DEPTH(NWORDS)) u_vcnt (
		.clk(clk), .we(vc_we), .waddr(vc_wa), .wdata(vc_wd),
		.re(vc_re), .raddr(vc_ra), .rdata(vc_rd)
	);
	dlcr_ram #(.WIDTH(CNT_W), .DEPTH(NWORDS)) u_tcnt (
		.clk(clk), .we(tc_we), .waddr(tc_wa), .wdata(tc_wd),
		.re(tc_re), .raddr(tc_ra), .rdata(tc_rd)
	);
	dlcr_ram #(.WIDTH($bits(ivl_t)), .DEPTH(MAX_INTERVALS)) u_ivl (
		.clk(clk), .we(iv_we), .waddr(iv_wa), .wdata(iv_wd),
		.re(iv_re), .raddr(iv_ra), .rdata(iv_rd)
	);

	assign can_emit  = !pend_v_q || !out_v_q || out_ready;
	assign can_flush = !out_v_q || out_ready;

	assign run_inc    = (run_q == POS_MAX) ? run_q : run_q + POS_W'(1);
	assign trip_new   = {trip_q[WORD_W-3:0], q_item.base_code[1:0]};
	assign span       = (run_inc >= POS_W'(WINDOW)) ? POS_W'(WINDOW) : run_inc;
	assign wstart_new = pos_q + POS_W'(1) - span;

	assign cw        = wval_q[bw_q] ? wc_rd : '0;
	assign cv        = vval_q[bw_q] ? vc_rd : '0;
	assign cw_dec    = dec_sat(cw);
	assign cv_dec    = dec_sat(cv);
	assign wtot_take = sub_sat(wtot_q, cw_dec);
	assign vtot_take = sub_sat(vtot_q, cv_dec);
	assign ct        = tval_q[bw_q] ? tc_rd : cv;
	assign ts_new    = tscore_q + TOT_W'(ct);

	assign lhs    = PROD_W'(wtot_q) * PROD_W'(SCORE_MUL);
	assign rhs    = PROD_W'(vlen_q) * PROD_W'(thr);
	assign go_src = lhs > rhs;

	// next state, ram control, result generation
	always_comb begin
		state_d = state_q;
		q_ready = 1'b0;
		emit    = 1'b0;
		flush   = 1'b0;
		emit_s  = iv_rd.start;
		emit_e  = iv_rd.stop;
		rg_we = 1'b0; rg_re = 1'b0; rg_wa = '0; rg_ra = '0; rg_wd = trip_q;
		wc_we = 1'b0; wc_re = 1'b0; wc_wa = bw_q; wc_ra = '0; wc_wd = '0;
		vc_we = 1'b0; vc_re = 1'b0; vc_wa = bw_q; vc_ra = '0; vc_wd = '0;
		tc_we = 1'b0; tc_re = 1'b0; tc_wa = bw_q; tc_ra = '0; tc_wd = '0;
		iv_we = 1'b0; iv_re = 1'b0; iv_wa = '0; iv_ra = '0; iv_wd = iv_rd;
		lhs2 = '0;
		rhs2 = '0;
		case (state_q)
			S_IDLE: begin
				if (q_valid) begin
					q_ready = 1'b1;
					if (q_item.amb) begin
						state_d = (thr != '0 && cnt_q != '0) ? S_AMB_RD : S_FIN;
					end else if (run_inc < POS_W'(TRIPLET_LEN)) begin
						state_d = S_FIN;
					end else if (cnt_q != '0) begin
						state_d = S_CMP_RD;
					end else begin
						state_d = (fill_q == FILL_W'(RING)) ? S_OLD_RD : S_NEW_CNT;
					end
				end
			end
			S_AMB_RD: begin
				iv_re   = 1'b1;
				iv_ra   = IIDX_W'(kp_q - ICNT_W'(1));
				state_d = S_AMB_EM;
			end
			S_AMB_EM: begin
				if (can_emit) begin
					emit    = 1'b1;
					state_d = (kp_q == ICNT_W'(1)) ? S_FIN : S_AMB_RD;
				end
			end
			S_CMP_RD: begin
				iv_re   = 1'b1;
				iv_ra   = IIDX_W'(k_q);
				state_d = S_CMP_DO;
			end
			S_CMP_DO: begin
				if (iv_rd.start >= wstart_q || can_emit) begin
					if (iv_rd.start < wstart_q) begin
						emit = 1'b1;
					end else begin
						iv_we = 1'b1;
						iv_wa = IIDX_W'(keep_q);
					end
					if (k_q + ICNT_W'(1) == cnt_q) begin
						state_d = (fill_q == FILL_W'(RING)) ? S_OLD_RD : S_NEW_CNT;
					end else begin
						state_d = S_CMP_RD;
					end
				end
			end
			S_OLD_RD: begin
				rg_re   = 1'b1;
				rg_ra   = head_q;
				state_d = S_OLD_CNT;
			end
			S_OLD_CNT: begin
				wc_re   = 1'b1;
				wc_ra   = rg_rd;
				vc_re   = 1'b1;
				vc_ra   = rg_rd;
				state_d = S_OLD_UPD;
			end
			S_OLD_UPD: begin
				wc_we = 1'b1;
				wc_wd = cw_dec;
				if (vlen_q > FILL_W'(RING - 1)) begin
					vc_we = 1'b1;
					vc_wd = cv_dec;
				end
				state_d = S_NEW_CNT;
			end
			S_NEW_CNT: begin
				rg_we   = 1'b1;
				rg_wa   = ring_phys(head_q, fill_q);
				wc_re   = 1'b1;
				wc_ra   = trip_q;
				vc_re   = 1'b1;
				vc_ra   = trip_q;
				state_d = S_NEW_UPD;
			end
			S_NEW_UPD: begin
				wc_we = 1'b1;
				wc_wd = cw + CNT_W'(1);
				vc_we = 1'b1;
				vc_wd = cv + CNT_W'(1);
				lhs2  = PROD_W'(cv + CNT_W'(1)) * PROD_W'(SCORE_MUL);
				rhs2  = PROD_W'(thr) * PROD_W'(TRIM_MUL);
				if (lhs2 > rhs2 && vlen_q != '0 && vlen_q <= fill_q) begin
					state_d = S_TRIM_RD;
				end else begin
					state_d = S_CHK;
				end
			end
			S_TRIM_RD: begin
				rg_re   = 1'b1;
				rg_ra   = ring_phys(head_q, fill_q - vlen_q);
				state_d = S_TRIM_CNT;
			end
			S_TRIM_CNT: begin
				vc_re   = 1'b1;
				vc_ra   = rg_rd;
				state_d = S_TRIM_UPD;
			end
			S_TRIM_UPD: begin
				vc_we = 1'b1;
				vc_wd = cv_dec;
				if (bw_q == trip_q) begin
					state_d = S_CHK;
				end else if (vlen_q != FILL_W'(1) && vlen_q - FILL_W'(1) <= fill_q) begin
					state_d = S_TRIM_RD;
				end else begin
					state_d = S_CHK;
				end
			end
			S_CHK: begin
				state_d = (go_src && fill_q != vlen_q) ? S_SRC_RD : S_FIN;
			end
			S_SRC_RD: begin
				rg_re   = 1'b1;
				rg_ra   = ring_phys(head_q, jp_q - FILL_W'(1));
				state_d = S_SRC_CNT;
			end
			S_SRC_CNT: begin
				tc_re   = 1'b1;
				tc_ra   = rg_rd;
				vc_re   = 1'b1;
				vc_ra   = rg_rd;
				state_d = S_SRC_UPD;
			end
			S_SRC_UPD: begin
				tc_we   = 1'b1;
				tc_wd   = ct + CNT_W'(1);
				state_d = S_SRC_TST;
			end
			S_SRC_TST: begin
				lhs2 = PROD_W'(tscore_q) * PROD_W'(SCORE_MUL);
				rhs2 = PROD_W'(thr) * PROD_W'(tlen_q);
				if (lhs2 > rhs2) begin
					state_d = (cnt_q == '0) ? S_DEC : S_SCN_RD;
				end else begin
					state_d = (jp_q == FILL_W'(1)) ? S_FIN : S_SRC_RD;
				end
			end
			S_SCN_RD: begin
				iv_re   = 1'b1;
				iv_ra   = IIDX_W'(kp_q - ICNT_W'(1));
				state_d = S_SCN_DO;
			end
			S_SCN_DO: begin
				if (iv_rd.start < istart_q || kp_q == ICNT_W'(1)) begin
					state_d = S_DEC;
				end else begin
					state_d = S_SCN_RD;
				end
			end
			S_DEC: begin
				lhs2 = PROD_W'(tscore_q) * PROD_W'(best_l_q);
				rhs2 = PROD_W'(best_s_q) * PROD_W'(tlen_q);
				if ((best_s_q == '0 || lhs2 >= rhs2) && cnt_q < ICNT_W'(MAX_INTERVALS)) begin
					state_d = (cnt_q > ins_q) ? S_SHF_RD : S_INS;
				end else begin
					state_d = (jp_q == FILL_W'(1)) ? S_FIN : S_SRC_RD;
				end
			end
			S_SHF_RD: begin
				iv_re   = 1'b1;
				iv_ra   = IIDX_W'(kp_q - ICNT_W'(1));
				state_d = S_SHF_WR;
			end
			S_SHF_WR: begin
				iv_we   = 1'b1;
				iv_wa   = IIDX_W'(kp_q);
				state_d = (kp_q - ICNT_W'(1) == ins_q) ? S_INS : S_SHF_RD;
			end
			S_INS: begin
				iv_we       = 1'b1;
				iv_wa       = IIDX_W'(ins_q);
				iv_wd.start = istart_q;
				iv_wd.stop  = POS_W'(fill_q) + POS_W'(TRIPLET_LEN - 1) + wstart_q;
				iv_wd.score = tscore_q;
				iv_wd.len   = tlen_q;
				state_d     = (jp_q == FILL_W'(1)) ? S_FIN : S_SRC_RD;
			end
			S_FIN: begin
				if (!pend_v_q || can_flush) begin
					flush   = pend_v_q;
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// datapath and model state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			run_q    <= '0;
			trip_q   <= '0;
			head_q   <= '0;
			fill_q   <= '0;
			vlen_q   <= '0;
			wtot_q   <= '0;
			vtot_q   <= '0;
			cnt_q    <= '0;
			wval_q   <= '0;
			vval_q   <= '0;
			tval_q   <= '0;
			end_q    <= 1'b0;
			amb_q    <= 1'b0;
			wstart_q <= '0;
			istart_q <= '0;
			bw_q     <= '0;
			jp_q     <= '0;
			tlen_q   <= '0;
			tscore_q <= '0;
			best_s_q <= '0;
			best_l_q <= '0;
			k_q      <= '0;
			keep_q   <= '0;
			kp_q     <= '0;
			ins_q    <= '0;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (q_valid) begin
						end_q <= q_item.sequence_end;
						amb_q <= q_item.amb;
						kp_q  <= cnt_q;
						k_q   <= '0;
						keep_q <= '0;
						if (!q_item.amb) begin
							run_q    <= run_inc;
							trip_q   <= trip_new;
							wstart_q <= wstart_new;
						end
					end
				end
				S_AMB_EM: begin
					if (can_emit) begin
						kp_q <= kp_q - ICNT_W'(1);
					end
				end
				S_CMP_DO: begin
					if (iv_rd.start >= wstart_q || can_emit) begin
						k_q <= k_q + ICNT_W'(1);
						if (iv_rd.start >= wstart_q) begin
							keep_q <= keep_q + ICNT_W'(1);
						end
						if (k_q + ICNT_W'(1) == cnt_q) begin
							cnt_q <= (iv_rd.start >= wstart_q) ? keep_q + ICNT_W'(1) : keep_q;
						end
					end
				end
				S_OLD_CNT: begin
					bw_q <= rg_rd;
				end
				S_OLD_UPD: begin
					wtot_q       <= wtot_take;
					wval_q[bw_q] <= 1'b1;
					if (vlen_q > FILL_W'(RING - 1)) begin
						vlen_q       <= vlen_q - FILL_W'(1);
						vtot_q       <= vtot_take;
						vval_q[bw_q] <= 1'b1;
					end
					head_q <= ring_phys(head_q, FILL_W'(1));
					fill_q <= FILL_W'(RING - 1);
				end
				S_NEW_CNT: begin
					bw_q   <= trip_q;
					fill_q <= fill_q + FILL_W'(1);
					vlen_q <= vlen_q + FILL_W'(1);
				end
				S_NEW_UPD: begin
					wtot_q       <= wtot_q + TOT_W'(cw);
					vtot_q       <= vtot_q + TOT_W'(cv);
					wval_q[bw_q] <= 1'b1;
					vval_q[bw_q] <= 1'b1;
				end
				S_TRIM_CNT: begin
					bw_q <= rg_rd;
				end
				S_TRIM_UPD: begin
					vtot_q       <= vtot_take;
					vval_q[bw_q] <= 1'b1;
					vlen_q       <= vlen_q - FILL_W'(1);
				end
				S_CHK: begin
					tscore_q <= vtot_q;
					best_s_q <= '0;
					best_l_q <= '0;
					tval_q   <= '0;
					jp_q     <= fill_q - vlen_q;
				end
				S_SRC_CNT: begin
					bw_q <= rg_rd;
				end
				S_SRC_UPD: begin
					tscore_q     <= ts_new;
					tval_q[bw_q] <= 1'b1;
					tlen_q       <= fill_q - jp_q;
					istart_q     <= POS_W'(jp_q - FILL_W'(1)) + wstart_q;
				end
				S_SRC_TST: begin
					kp_q  <= cnt_q;
					ins_q <= '0;
					if (!(lhs2 > rhs2)) begin
						jp_q <= jp_q - FILL_W'(1);
					end
				end
				S_SCN_DO: begin
					if (iv_rd.start < istart_q) begin
						ins_q <= kp_q;
					end else begin
						if (best_s_q == '0 || PROD_W'(iv_rd.score) * PROD_W'(best_l_q)
							> PROD_W'(best_s_q) * PROD_W'(iv_rd.len)) begin
							best_s_q <= iv_rd.score;
							best_l_q <= iv_rd.len;
						end
						kp_q <= kp_q - ICNT_W'(1);
					end
				end
				S_DEC: begin
					kp_q <= cnt_q;
					if (best_s_q == '0 || lhs2 >= rhs2) begin
						best_s_q <= tscore_q;
						best_l_q <= tlen_q;
					end
					if (!((best_s_q == '0 || lhs2 >= rhs2) && cnt_q < ICNT_W'(MAX_INTERVALS))) begin
						jp_q <= jp_q - FILL_W'(1);
					end
				end
				S_SHF_WR: begin
					kp_q <= kp_q - ICNT_W'(1);
				end
				S_INS: begin
					cnt_q <= cnt_q + ICNT_W'(1);
					jp_q  <= jp_q - FILL_W'(1);
				end
				S_FIN: begin
					if (!pend_v_q || can_flush) begin
						pos_q <= (amb_q && end_q) ? '0 : pos_q + POS_W'(1);
						if (amb_q) begin
							run_q  <= '0;
							trip_q <= '0;
							fill_q <= '0;
							vlen_q <= '0;
							wtot_q <= '0;
							vtot_q <= '0;
							cnt_q  <= '0;
							wval_q <= '0;
							vval_q <= '0;
						end
					end
				end
				default: begin
				end
			endcase
		end
	end

	// one result held back so that the last of an item can be marked
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pend_v_q <= 1'b0;
			out_v_q  <= 1'b0;
		end else begin
			if (out_v_q && out_ready) begin
				out_v_q <= 1'b0;
			end
			if (emit) begin
				pend_v_q <= 1'b1;
				if (pend_v_q) begin
					out_v_q <= 1'b1;
				end
			end
			if (flush) begin
				pend_v_q <= 1'b0;
				out_v_q  <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			pend_s_q <= emit_s;
			pend_e_q <= emit_e;
			if (pend_v_q) begin
				out_q <= '{region_start: pend_s_q, region_end: pend_e_q, last_of_run: 1'b0};
			end
		end
		if (flush) begin
			out_q <= '{region_start: pend_s_q, region_end: pend_e_q, last_of_run: 1'b1};
		end
	end

	assign out_valid = out_v_q;
	assign out_data  = out_q;

	always_comb begin
		stat.busy    = (state_q != S_IDLE);
		stat.ivl_cnt = cnt_q;
		stat.fill    = fill_q;
		stat.vlen    = vlen_q;
	end

endmodule

// ----- bench/tb.sv -----
// testbench for the dust low-complexity region finder top level
// predicts the emitted regions per base transfer and checks each output transfer
// depends on dlcr_pkg and dust_low_complexity_region_finder_top
`timescale 1ns / 100ps

module tb;
	import dlcr_pkg::*;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic in_valid = 1'b0;
	logic in_ready;
	in_item_t in_data = '0;
	logic out_valid;
	logic out_ready = 1'b0;
	out_item_t out_data;
	logic cfg_wr_en = 1'b0;
	logic [THR_W-1:0] cfg_wr_data = '0;

	dust_low_complexity_region_finder_top dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready), .in_data(in_data),
		.out_valid(out_valid), .out_ready(out_ready), .out_data(out_data),
		.cfg_wr_en(cfg_wr_en), .cfg_wr_data(cfg_wr_data)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	localparam logic [31:0] PMASK = 32'h7fff_ffff;

	// predictor state
	int unsigned thr_m;
	int unsigned pos_m, run_m, trip_m, fill_m, wtot_m, vtot_m, vlen_m, icnt_m;
	int unsigned ring_m[RING];
	int unsigned wcnt_m[NWORDS];
	int unsigned vcnt_m[NWORDS];
	int unsigned ib0[MAX_INTERVALS], ib1[MAX_INTERVALS];
	int unsigned is0[MAX_INTERVALS], is1[MAX_INTERVALS];

	out_item_t regions_due[$];
	int errors = 0;
	int n_in = 0, n_out = 0;
	int send_idle_pct = 0, recv_stall_pct = 0;
	bit hold_off = 1'b0;

	task automatic report(input string what);
		errors++;
		$display("mismatch: %s", what);
	endtask

	function automatic void clear_run();
		run_m = 0; trip_m = 0; fill_m = 0;
		foreach (wcnt_m[i]) begin
			wcnt_m[i] = 0;
			vcnt_m[i] = 0;
		end
		wtot_m = 0; vtot_m = 0; vlen_m = 0; icnt_m = 0;
	endfunction

	function automatic void take(ref int unsigned tot, ref int unsigned c);
		if (c > 0) c--;
		tot = (tot >= c) ? tot - c : 0;
	endfunction

	function automatic void push_region(int unsigned s, int unsigned e);
		out_item_t r;
		r.region_start = s[30:0];
		r.region_end = e[30:0];
		r.last_of_run = 1'b0;
		regions_due = {regions_due, r};
	endfunction

	function automatic void search_window(int unsigned wstart);
		int unsigned tmp[NWORDS];
		longint unsigned tscore, best_s, best_l;
		int unsigned w, tlen, istart, ins;
		tmp = vcnt_m;
		tscore = vtot_m; best_s = 0; best_l = 0;
		for (int j = int'(fill_m) - int'(vlen_m) - 1; j >= 0; j--) begin
			w = ring_m[j];
			tlen = fill_m - j - 1;
			istart = (j + wstart) & PMASK;
			ins = 0;
			tscore += tmp[w];
			tmp[w]++;
			if (!(tscore * 10 > longint'(thr_m) * tlen)) continue;
			for (int k = int'(icnt_m) - 1; k >= 0; k--) begin
				if (ib0[k] < istart) begin
					ins = k + 1;
					break;
				end
				if (best_s == 0 || longint'(is0[k]) * best_l > best_s * is1[k]) begin
					best_s = is0[k];
					best_l = is1[k];
				end
			end
			if (best_s == 0 || tscore * best_l >= best_s * tlen) begin
				best_s = tscore;
				best_l = tlen;
				if (icnt_m < MAX_INTERVALS) begin
					for (int k = int'(icnt_m) - 1; k >= int'(ins); k--) begin
						ib0[k+1] = ib0[k]; ib1[k+1] = ib1[k];
						is0[k+1] = is0[k]; is1[k+1] = is1[k];
					end
					ib0[ins] = istart;
					ib1[ins] = (fill_m + TRIPLET_LEN - 1 + wstart) & PMASK;
					is0[ins] = tscore;
					is1[ins] = tlen;
					icnt_m++;
				end
			end
		end
	endfunction

	function automatic void predict_regions(in_item_t it);
		int unsigned bc, p, n0, span, wstart, w, keep, old, bw;
		bc = it.base_code;
		p = pos_m;
		n0 = regions_due.size();
		if (it.sequence_end || bc > BASE_MAX || thr_m == 0) begin
			if (thr_m != 0)
				for (int k = int'(icnt_m) - 1; k >= 0; k--)
					push_region(ib0[k], ib1[k]);
			clear_run();
			pos_m = it.sequence_end ? 0 : ((p + 1) & PMASK);
		end else begin
			if (run_m < PMASK) run_m++;
			trip_m = ((trip_m << 2) | bc) & (NWORDS - 1);
			if (run_m >= TRIPLET_LEN) begin
				span = (run_m >= WINDOW) ? WINDOW : run_m;
				wstart = (p + 1 - span) & PMASK;
				w = trip_m;
				keep = 0;
				for (int k = 0; k < int'(icnt_m); k++) begin
					if (ib0[k] < wstart) push_region(ib0[k], ib1[k]);
					else begin
						ib0[keep] = ib0[k]; ib1[keep] = ib1[k];
						is0[keep] = is0[k]; is1[keep] = is1[k];
						keep++;
					end
				end
				icnt_m = keep;
				if (fill_m >= RING) begin
					old = ring_m[0];
					for (int k = 0; k < RING - 1; k++) ring_m[k] = ring_m[k+1];
					fill_m = RING - 1;
					take(wtot_m, wcnt_m[old]);
					if (vlen_m > fill_m) begin
						vlen_m--;
						take(vtot_m, vcnt_m[old]);
					end
				end
				ring_m[fill_m] = w;
				fill_m++;
				vlen_m++;
				wtot_m += wcnt_m[w]; wcnt_m[w]++;
				vtot_m += vcnt_m[w]; vcnt_m[w]++;
				if (vcnt_m[w] * 10 > thr_m * 2) begin
					while (vlen_m > 0 && vlen_m <= fill_m) begin
						bw = ring_m[fill_m - vlen_m];
						take(vtot_m, vcnt_m[bw]);
						vlen_m--;
						if (bw == w) break;
					end
				end
				if (wtot_m * 10 > vlen_m * thr_m) search_window(wstart);
			end
			pos_m = (p + 1) & PMASK;
		end
		if (regions_due.size() > n0)
			regions_due[regions_due.size()-1].last_of_run = 1'b1;
	endfunction

	// one item per call; valid held until the transfer
	task automatic send_base(input logic [2:0] bc, input logic e);
		in_item_t it;
		it.base_code = bc;
		it.sequence_end = e;
		while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		in_data <= it;
		@(posedge clk);
		while (!in_ready) @(posedge clk);
		predict_regions(it);
		n_in++;
		@(negedge clk);
	endtask

	task automatic sender_rest();
		in_valid <= 1'b0;
	endtask

	task automatic wait_drained();
		int guard = 0;
		sender_rest();
		while ((regions_due.size() != 0 || dut.q_valid || dut.stat.busy)
			&& guard < 200000) begin
			@(negedge clk);
			guard++;
		end
		repeat (4) @(negedge clk);
	endtask

	task automatic write_threshold(input logic [7:0] v);
		wait_drained();
		cfg_wr_en <= 1'b1;
		cfg_wr_data <= v;
		@(negedge clk);
		cfg_wr_en <= 1'b0;
		thr_m = v;
	endtask

	always @(negedge clk) begin
		if (hold_off) out_ready <= 1'b0;
		else out_ready <= !(recv_stall_pct > 0 && $urandom_range(99) < recv_stall_pct);
	end

	always @(posedge clk) begin
		out_item_t exp_r;
		if (arst_n && out_valid && out_ready) begin
			n_out++;
			if (regions_due.size() == 0) report("region with none expected");
			else begin
				exp_r = regions_due[0];
				regions_due.delete(0);
				if (out_data.region_start !== exp_r.region_start)
					report($sformatf("start %0d exp %0d", out_data.region_start,
						exp_r.region_start));
				if (out_data.region_end !== exp_r.region_end)
					report($sformatf("end %0d exp %0d", out_data.region_end,
						exp_r.region_end));
				if (out_data.last_of_run !== exp_r.last_of_run)
					report($sformatf("last_of_run %0b exp %0b", out_data.last_of_run,
						exp_r.last_of_run));
			end
		end
	end

	task automatic send_repeat(input int len, input int period);
		int unsigned pat[4];
		foreach (pat[i]) pat[i] = $urandom_range(3);
		for (int i = 0; i < len; i++) send_base(3'(pat[i % period]), 1'b0);
	endtask

	task automatic test_directed();
		send_base(3'd0, 1'b0);
		send_base(3'd7, 1'b0);
		for (int i = 0; i < 12; i++) send_base(3'd0, 1'b0);
		send_base(3'd4, 1'b0);
		for (int i = 0; i < 6; i++) send_base(3'(i[1:0]), 1'b0);
		send_base(3'd5, 1'b1);
	endtask

	task automatic test_threshold_sweep();
		logic [7:0] thrs[4] = '{8'd0, 8'd1, 8'd255, 8'd20};
		foreach (thrs[i]) begin
			write_threshold(thrs[i]);
			send_repeat(10, 1);
			send_base(3'd6, 1'b0);
			send_repeat(8, 2);
			send_base(3'd0, 1'b1);
		end
	endtask

	task automatic test_random(input int items);
		int cnt = 0, len;
		while (cnt < items) begin
			case ($urandom_range(9))
				0: begin
					send_base(3'($urandom_range(7)), 1'($urandom_range(1)));
					cnt++;
				end
				1, 2, 3, 4: begin
					len = $urandom_range(4, 20);
					send_repeat(len, $urandom_range(1, 4));
					cnt += len;
				end
				default: begin
					len = $urandom_range(3, 12);
					for (int i = 0; i < len; i++) send_base(3'($urandom_range(3)), 1'b0);
					cnt += len;
				end
			endcase
		end
		send_base(3'd0, 1'b1);
	endtask

	task automatic test_backpressure();
		fork
			begin
				hold_off = 1'b1;
				repeat (2000) @(negedge clk);
				hold_off = 1'b0;
			end
			begin
				send_repeat(30, 1);
				send_base(3'd4, 1'b0);
				send_repeat(10, 1);
				sender_rest();
			end
		join
		send_base(3'd4, 1'b0);
		wait_drained();
		send_repeat(12, 2);
		send_base(3'd0, 1'b1);
	endtask

	initial begin
		thr_m = THR_RESET;
		pos_m = 0;
		clear_run();
		repeat (3) @(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_directed();
		test_threshold_sweep();
		test_backpressure();
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(14);
		write_threshold(8'd12);
		send_idle_pct = 61; recv_stall_pct = 0;
		test_random(14);
		send_idle_pct = 0; recv_stall_pct = 61;
		test_random(14);
		write_threshold(8'd30);
		send_idle_pct = 23; recv_stall_pct = 23;
		test_random(14);
		write_threshold(8'd255);
		send_idle_pct = 0; recv_stall_pct = 0;
		test_random(14);
		wait_drained();
		$display("covered %0d base transfers and %0d region transfers", n_in, n_out);
		$display("thresholds zero, one, low, default and maximum, with idling and stalls");
		if (errors == 0 && regions_due.size() == 0)
			$display("tb passed");
		else
			$display("tb failed");
		$finish;
	end

	initial begin
		#400ms;
		$display("tb failed");
		$finish;
	end
endmodule
